// ===== hw/rtl/dfp_pkg.sv =====
`default_nettype none

package dfp_pkg;

    // field text limits
    localparam int MAX_FRACTION_DIGITS = 5;
    localparam int INT_W   = 32;
    localparam int FRAC_W  = $clog2(10 ** MAX_FRACTION_DIGITS);
    localparam int COUNT_W = 3;
    localparam int CHAR_W  = 8;

    // queue depths
    localparam int FIELD_QUEUE_DEPTH  = 2;
    localparam int RESULT_QUEUE_DEPTH = 2;

    // character codes
    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_POINT = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

    // one finished field handed from front to back
    typedef struct packed {
        logic [INT_W-1:0]   int_part;
        logic [FRAC_W-1:0]  frac_part;
        logic [COUNT_W-1:0] count;
        logic               negative;
        logic               illegal;
    } field_t;

    // one result transaction
    typedef struct packed {
        logic signed [INT_W-1:0] value;
        logic [COUNT_W-1:0]      decimals;
        logic                    bad_char;
    } result_t;

    // ten to the given power, low word
    function automatic logic [INT_W-1:0] pow10(input logic [COUNT_W-1:0] n);
        logic [INT_W-1:0] p;
        p = INT_W'(1);
        for (int k = 0; k < MAX_FRACTION_DIGITS; k++)
        begin
            if (COUNT_W'(k) < n)
            begin
                p = (p << 3) + (p << 1);
            end
        end
        return p;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/decimal_field_to_fixed_point.sv =====
`default_nettype none

// channel   handshake        payload
// input     push / full      character[7:0]
// result    empty / pop      value[31:0] signed, decimals[2:0], bad_char
//
// one character per cycle is taken unless full; the front updates its accumulators
// a terminator leaves a field in a two-entry queue; the back scales it with one
// 32x32 multiply, adds the fraction, applies the sign: the field passes through the
// scale and sum registers into a result queue, whose oldest entry is on the ports
// full is high while the field queue holds two fields, even if the back can take one
// reset is asynchronous, active low, and empties every queue at once

module decimal_field_to_fixed_point (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          push,
    output logic                               full,
    input  wire logic [7:0]                    character,
    output logic                               empty,
    input  wire logic                          pop,
    output logic signed [31:0]                 value,
    output logic [2:0]                         decimals,
    output logic                               bad_char
);

    logic               accept;
    logic               field_push;
    dfp_pkg::field_t    field_data;
    logic               q_valid;
    logic               q_pop;
    dfp_pkg::field_t    q_data;

    // input transaction
    assign accept = push && !full;

    dfp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .character  (character),
        .field_push (field_push),
        .field_data (field_data)
    );

    dfp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (field_push),
        .wr_data  (field_data),
        .full     (full),
        .rd_valid (q_valid),
        .rd_en    (q_pop),
        .rd_data  (q_data)
    );

    dfp_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (q_valid),
        .in_data  (q_data),
        .in_ready (q_pop),
        .empty    (empty),
        .pop      (pop),
        .value    (value),
        .decimals (decimals),
        .bad_char (bad_char)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/dfp_front.sv =====
`default_nettype none

module dfp_front (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         accept,
    input  wire logic [dfp_pkg::CHAR_W-1:0]   character,
    output logic                              field_push,
    output dfp_pkg::field_t                   field_data
);

    logic [dfp_pkg::INT_W-1:0]   int_reg, int_next;
    logic [dfp_pkg::FRAC_W-1:0]  frac_reg, frac_next;
    logic [dfp_pkg::COUNT_W-1:0] count_reg, count_next;
    logic                        point_reg, point_next;
    logic                        neg_reg, neg_next;
    logic                        illegal_reg, illegal_next;

    logic                        is_term;
    logic                        is_digit;
    logic [3:0]                  digit;

    // classify the incoming character
    always_comb
    begin
        is_term  = character inside {dfp_pkg::CH_COMMA, dfp_pkg::CH_STAR,
                                     dfp_pkg::CH_SPACE, dfp_pkg::CH_CR,
                                     dfp_pkg::CH_NUL};
        is_digit = character inside {[dfp_pkg::CH_ZERO:dfp_pkg::CH_NINE]};
        digit    = 4'(character - dfp_pkg::CH_ZERO);
    end

    // accumulator update
    always_comb
    begin
        int_next     = int_reg;
        frac_next    = frac_reg;
        count_next   = count_reg;
        point_next   = point_reg;
        neg_next     = neg_reg;
        illegal_next = illegal_reg;
        if (accept)
        begin
            if (is_term)
            begin
                int_next     = '0;
                frac_next    = '0;
                count_next   = '0;
                point_next   = 1'b0;
                neg_next     = 1'b0;
                illegal_next = 1'b0;
            end
            else if (!illegal_reg)
            begin
                if (character == dfp_pkg::CH_MINUS)
                begin
                    neg_next = 1'b1;
                end
                else if (character == dfp_pkg::CH_POINT)
                begin
                    if (point_reg)
                        illegal_next = 1'b1;
                    else
                        point_next = 1'b1;
                end
                else if (is_digit)
                begin
                    if (!point_reg)
                    begin
                        int_next = (int_reg << 3) + (int_reg << 1)
                                   + dfp_pkg::INT_W'(digit);
                    end
                    else if (count_reg < dfp_pkg::COUNT_W'(dfp_pkg::MAX_FRACTION_DIGITS))
                    begin
                        frac_next  = (frac_reg << 3) + (frac_reg << 1)
                                     + dfp_pkg::FRAC_W'(digit);
                        count_next = count_reg + dfp_pkg::COUNT_W'(1);
                    end
                end
                else
                begin
                    illegal_next = 1'b1;
                end
            end
        end
    end

    // hand the finished field to the queue, zeroed when illegal
    always_comb
    begin
        field_push = accept && is_term;
        field_data = '0;
        if (illegal_reg)
        begin
            field_data.illegal = 1'b1;
        end
        else
        begin
            field_data.int_part  = int_reg;
            field_data.frac_part = frac_reg;
            field_data.count     = count_reg;
            field_data.negative  = neg_reg;
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            int_reg     <= '0;
            frac_reg    <= '0;
            count_reg   <= '0;
            point_reg   <= 1'b0;
            neg_reg     <= 1'b0;
            illegal_reg <= 1'b0;
        end
        else
        begin
            int_reg     <= int_next;
            frac_reg    <= frac_next;
            count_reg   <= count_next;
            point_reg   <= point_next;
            neg_reg     <= neg_next;
            illegal_reg <= illegal_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/dfp_queue.sv =====
`default_nettype none

module dfp_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            wr_en,
    input  wire dfp_pkg::field_t wr_data,
    output logic                 full,
    output logic                 rd_valid,
    input  wire logic            rd_en,
    output dfp_pkg::field_t      rd_data
);

    localparam int DEPTH = dfp_pkg::FIELD_QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    dfp_pkg::field_t    entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               do_wr, do_rd;

    // status and head
    always_comb
    begin
        full     = (cnt_reg == CNT_W'(DEPTH));
        rd_valid = (cnt_reg != '0);
        rd_data  = entry_reg[rd_ptr_reg];
        do_wr    = wr_en && !full;
        do_rd    = rd_en && rd_valid;
    end

    // pointer and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        cnt_next = cnt_reg + CNT_W'(do_wr) - CNT_W'(do_rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
            entry_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/dfp_back.sv =====
`default_nettype none

module dfp_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    input  wire dfp_pkg::field_t               in_data,
    output logic                               in_ready,
    output logic                               empty,
    input  wire logic                          pop,
    output logic signed [dfp_pkg::INT_W-1:0]   value,
    output logic [dfp_pkg::COUNT_W-1:0]        decimals,
    output logic                               bad_char
);

    localparam int DEPTH = dfp_pkg::RESULT_QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    // scale stage
    logic                          s1_valid_reg;
    logic [dfp_pkg::INT_W-1:0]     s1_prod_reg;
    logic [dfp_pkg::FRAC_W-1:0]    s1_frac_reg;
    logic [dfp_pkg::COUNT_W-1:0]   s1_count_reg;
    logic                          s1_neg_reg;
    logic                          s1_illegal_reg;

    // sum stage
    logic                          s2_valid_reg;
    logic [dfp_pkg::INT_W-1:0]     s2_sum_reg;
    logic [dfp_pkg::COUNT_W-1:0]   s2_count_reg;
    logic                          s2_neg_reg;
    logic                          s2_illegal_reg;

    // result queue
    dfp_pkg::result_t              oq_reg [DEPTH];
    logic [PTR_W-1:0]              oq_wr_ptr_reg, oq_rd_ptr_reg;
    logic [CNT_W-1:0]              oq_cnt_reg;

    logic                          oq_full;
    logic                          s1_ready, s2_ready, s1_load, s2_load, oq_wr, oq_rd;
    logic [dfp_pkg::INT_W-1:0]     product;
    dfp_pkg::result_t              result;

    // elastic stage control
    always_comb
    begin
        oq_full  = (oq_cnt_reg == CNT_W'(DEPTH));
        oq_wr    = s2_valid_reg && !oq_full;
        s2_ready = !s2_valid_reg || !oq_full;
        s1_ready = !s1_valid_reg || s2_ready;
        in_ready = s1_ready;
        s1_load  = in_valid && s1_ready;
        s2_load  = s1_valid_reg && s2_ready;
        empty    = (oq_cnt_reg == '0);
        oq_rd    = pop && !empty;
    end

    // integer part times ten to the fraction count, low word
    always_comb
    begin
        product = in_data.int_part * dfp_pkg::pow10(in_data.count);
    end

    // sign applied on the way into the result queue
    always_comb
    begin
        result.value    = s2_neg_reg ? (dfp_pkg::INT_W'(0) - s2_sum_reg) : s2_sum_reg;
        result.decimals = s2_count_reg;
        result.bad_char = s2_illegal_reg;
    end

    // stage valid bits and queue control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            oq_wr_ptr_reg <= '0;
            oq_rd_ptr_reg <= '0;
            oq_cnt_reg    <= '0;
        end
        else
        begin
            if (s1_ready)
                s1_valid_reg <= in_valid;
            if (s2_ready)
                s2_valid_reg <= s1_valid_reg;
            if (oq_wr)
                oq_wr_ptr_reg <= (oq_wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0
                                 : oq_wr_ptr_reg + 1'b1;
            if (oq_rd)
                oq_rd_ptr_reg <= (oq_rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0
                                 : oq_rd_ptr_reg + 1'b1;
            oq_cnt_reg <= oq_cnt_reg + CNT_W'(oq_wr) - CNT_W'(oq_rd);
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_prod_reg    <= product;
            s1_frac_reg    <= in_data.frac_part;
            s1_count_reg   <= in_data.count;
            s1_neg_reg     <= in_data.negative;
            s1_illegal_reg <= in_data.illegal;
        end
        if (s2_load)
        begin
            s2_sum_reg     <= s1_prod_reg + dfp_pkg::INT_W'(s1_frac_reg);
            s2_count_reg   <= s1_count_reg;
            s2_neg_reg     <= s1_neg_reg;
            s2_illegal_reg <= s1_illegal_reg;
        end
        if (oq_wr)
            oq_reg[oq_wr_ptr_reg] <= result;
    end

    // oldest result on the ports
    always_comb
    begin
        value    = oq_reg[oq_rd_ptr_reg].value;
        decimals = oq_reg[oq_rd_ptr_reg].decimals;
        bad_char = oq_reg[oq_rd_ptr_reg].bad_char;
    end

endmodule

`default_nettype wire
